// ===== rtl/bpu_pkg.sv =====
// Shared types and constants for the BMP pixel unpacker.
package bpu_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COL_W     = 13;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned RBC_W     = 14;
  localparam int unsigned BPR_W     = 15;
  localparam int unsigned OUT_COL_W = 12;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_RUN   = 8;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned IDX_W     = 3;

  localparam logic [7:0] FULL_BYTE  = 8'hFF;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  typedef enum logic [1:0] {
    MODE_MONO         = 2'd0,
    MODE_BGR          = 2'd1,
    MODE_BITFIELD     = 2'd2,
    MODE_BITFIELD_ALT = 2'd3
  } pixel_mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_PIXEL_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_RED_POS      = 3'd3,
    REG_GREEN_POS    = 3'd4,
    REG_BLUE_POS     = 3'd5,
    REG_ALPHA_POS    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    pixel_mode_e      mode;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [POS_W-1:0] red_pos;
    logic [POS_W-1:0] green_pos;
    logic [POS_W-1:0] blue_pos;
    logic [POS_W-1:0] alpha_pos;
  } bpu_cfg_t;

  // Pixels produced by one byte: a run of count pixels at consecutive columns.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             mono;
    logic [7:0]       bits;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } bpu_run_t;

endpackage

// ===== rtl/bpu_byte_stage.sv =====
// Per-byte decode: row/column/pixel counters and the pixel run for each byte.
module bpu_byte_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpu_pkg::bpu_cfg_t      cfg_i,
  input  logic                   in_fire_i,
  input  logic [7:0]             data_byte_i,
  output bpu_pkg::bpu_run_t      run_o,
  output logic [bpu_pkg::DIM_W-1:0] eff_width_o
);
  import bpu_pkg::*;

  logic [RBC_W-1:0] rbc_q, rbc_d;
  logic [COL_W-1:0] pc_q, pc_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]       chan_q [4];
  logic [7:0]       chan_d [4];
  logic [1:0]       bip_q, bip_d;

  logic [DIM_W-1:0] w, h, avail;
  logic             mono, live, done, row_last, row_end;
  logic [CNT_W-1:0] mono_cnt, cnt;
  logic [2:0]       bip_inc, need;
  logic [BPR_W-1:0] raw_bytes, bpr;

  always_comb begin
    if (cfg_i.width == '0) begin
      w = DIM_W'(1);
    end else if (cfg_i.width > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = cfg_i.width;
    end
    if (cfg_i.height == '0) begin
      h = DIM_W'(1);
    end else if (cfg_i.height > DIM_W'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = cfg_i.height;
    end
  end

  assign eff_width_o = w;
  assign mono     = (cfg_i.mode == MODE_MONO);
  assign live     = (pc_q < w);
  assign avail    = w - pc_q;
  assign mono_cnt = (avail >= DIM_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : avail[CNT_W-1:0];
  assign bip_inc  = {1'b0, bip_q} + 3'd1;
  assign need     = (cfg_i.mode == MODE_BGR) ? 3'd3 : 3'd4;
  assign done     = live && !mono && (bip_inc >= need);
  assign row_last = (({1'b0, row_q} + DIM_W'(1)) >= h);

  always_comb begin
    case (cfg_i.mode)
      MODE_MONO: raw_bytes = ({2'b00, w} + BPR_W'(7)) >> 3;
      MODE_BGR:  raw_bytes = {2'b00, w} + {1'b0, w, 1'b0};
      default:   raw_bytes = {w, 2'b00};
    endcase
  end

  assign bpr     = (raw_bytes + BPR_W'(3)) & ~BPR_W'(3);
  assign row_end = (({1'b0, rbc_q} + BPR_W'(1)) >= bpr);

  always_comb begin
    chan_d = chan_q;
    if (live && !mono) begin
      chan_d[bip_q] = data_byte_i;
    end
  end

  always_comb begin
    if (mono) begin
      cnt = live ? mono_cnt : '0;
    end else begin
      cnt = done ? CNT_W'(1) : '0;
    end
  end

  always_comb begin
    run_o.count    = cnt;
    run_o.col      = pc_q;
    run_o.row      = row_q;
    run_o.last_row = row_last;
    run_o.mono     = mono;
    run_o.bits     = data_byte_i;
    case (cfg_i.mode)
      MODE_MONO: begin
        run_o.red   = EMPTY_BYTE;
        run_o.green = EMPTY_BYTE;
        run_o.blue  = EMPTY_BYTE;
        run_o.alpha = FULL_BYTE;
      end
      MODE_BGR: begin
        run_o.red   = chan_d[2];
        run_o.green = chan_d[1];
        run_o.blue  = chan_d[0];
        run_o.alpha = FULL_BYTE;
      end
      MODE_BITFIELD, MODE_BITFIELD_ALT: begin
        run_o.red   = chan_d[cfg_i.red_pos];
        run_o.green = chan_d[cfg_i.green_pos];
        run_o.blue  = chan_d[cfg_i.blue_pos];
        run_o.alpha = chan_d[cfg_i.alpha_pos];
      end
      default: begin
        run_o.red   = EMPTY_BYTE;
        run_o.green = EMPTY_BYTE;
        run_o.blue  = EMPTY_BYTE;
        run_o.alpha = FULL_BYTE;
      end
    endcase
  end

  always_comb begin
    pc_d  = pc_q + COL_W'(cnt);
    bip_d = bip_q;
    if (live && !mono) begin
      bip_d = done ? 2'd0 : bip_inc[1:0];
    end
    row_d = row_q;
    rbc_d = rbc_q + RBC_W'(1);
    if (row_end) begin
      rbc_d = '0;
      pc_d  = '0;
      bip_d = '0;
      row_d = row_last ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbc_q <= '0;
      pc_q  <= '0;
      row_q <= '0;
      bip_q <= '0;
      for (int i = 0; i < 4; i++) begin
        chan_q[i] <= '0;
      end
    end else if (in_fire_i) begin
      rbc_q  <= rbc_d;
      pc_q   <= pc_d;
      row_q  <= row_d;
      bip_q  <= bip_d;
      chan_q <= chan_d;
    end
  end

endmodule

// ===== rtl/bpu_pixel_out.sv =====
// Pixel run register and output register: one pixel beat per cycle while out_ready_i is high.
module bpu_pixel_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bpu_pkg::bpu_run_t             run_i,
  input  logic [bpu_pkg::DIM_W-1:0]     eff_width_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic [bpu_pkg::OUT_COL_W-1:0] column_o,
  output logic [bpu_pkg::ROW_W-1:0]     row_number_o,
  output logic                          last_of_run_o,
  output logic                          end_of_image_o
);
  import bpu_pkg::*;

  bpu_run_t run_q;
  logic     out_valid_q;
  logic     out_load, in_fire;
  logic [7:0] mono_val;

  assign out_load   = (run_q.count != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (run_q.count == '0) || ((run_q.count == CNT_W'(1)) && out_load);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mono_val   = run_q.bits[7] ? FULL_BYTE : EMPTY_BYTE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (in_fire && (run_i.count != '0)) begin
      run_q <= run_i;
    end else if (out_load) begin
      run_q.count <= run_q.count - CNT_W'(1);
      run_q.col   <= run_q.col + COL_W'(1);
      run_q.bits  <= {run_q.bits[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_o          <= run_q.mono ? mono_val : run_q.red;
      green_o        <= run_q.mono ? mono_val : run_q.green;
      blue_o         <= run_q.mono ? mono_val : run_q.blue;
      alpha_o        <= run_q.alpha;
      column_o       <= run_q.col[OUT_COL_W-1:0];
      row_number_o   <= run_q.row;
      last_of_run_o  <= (run_q.count == CNT_W'(1));
      end_of_image_o <= run_q.last_row && ((run_q.col + COL_W'(1)) == eff_width_i);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/bmp_pixel_unpacker_unit.sv =====
// BMP pixel unpacker top level: config registers, byte decode and pixel output.
// The first pixel of a byte passes through the pixel run register, then the output register.
// Throughput: one byte per cycle while the pixel run register can drain; output
// is one pixel per cycle while out_ready_i is high, so a mono byte holds the input until its run drains.
// Reset: counters and channel bytes clear, config returns to 24-bit BGR, 1x1.
module bmp_pixel_unpacker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpu_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [bpu_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic [bpu_pkg::OUT_COL_W-1:0] column_o,
  output logic [bpu_pkg::ROW_W-1:0]     row_number_o,
  output logic                          last_of_run_o,
  output logic                          end_of_image_o
);
  import bpu_pkg::*;

  bpu_cfg_t         cfg_q;
  bpu_run_t         run;
  logic [DIM_W-1:0] eff_width;
  logic             in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_BGR;
      cfg_q.width     <= DIM_W'(1);
      cfg_q.height    <= DIM_W'(1);
      cfg_q.red_pos   <= POS_W'(2);
      cfg_q.green_pos <= POS_W'(1);
      cfg_q.blue_pos  <= POS_W'(0);
      cfg_q.alpha_pos <= POS_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PIXEL_MODE:   cfg_q.mode      <= pixel_mode_e'(cfg_data_i[1:0]);
        REG_IMAGE_WIDTH:  cfg_q.width     <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_q.height    <= cfg_data_i;
        REG_RED_POS:      cfg_q.red_pos   <= cfg_data_i[POS_W-1:0];
        REG_GREEN_POS:    cfg_q.green_pos <= cfg_data_i[POS_W-1:0];
        REG_BLUE_POS:     cfg_q.blue_pos  <= cfg_data_i[POS_W-1:0];
        REG_ALPHA_POS:    cfg_q.alpha_pos <= cfg_data_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  bpu_byte_stage u_byte_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .run_o       (run),
    .eff_width_o (eff_width)
  );

  bpu_pixel_out u_pixel_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .run_i          (run),
    .eff_width_i    (eff_width),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .column_o       (column_o),
    .row_number_o   (row_number_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

// ===== dv/tb_bmp_pixel_unpacker_unit.sv =====
// Testbench for bmp_pixel_unpacker_unit: directed table, then random byte streams checked by a pixel predictor.
module tb_bmp_pixel_unpacker_unit;
  import bpu_pkg::*;

  localparam int unsigned RAND_ITEMS     = 280;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIR_N          = 27;

  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic [OUT_COL_W-1:0] column;
    logic [ROW_W-1:0]     row_number;
    logic                 last_of_run;
    logic                 end_of_image;
  } pixel_t;

  typedef enum logic {STIM_BYTE, STIM_CFG} stim_kind_e;

  typedef struct packed {
    stim_kind_e       kind;
    cfg_reg_e         reg_sel;
    logic [DIM_W-1:0] value;
    logic             pinned;
    pixel_t           pix;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IDX_W-1:0]     cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           red_o;
  logic [7:0]           green_o;
  logic [7:0]           blue_o;
  logic [7:0]           alpha_o;
  logic [OUT_COL_W-1:0] column_o;
  logic [ROW_W-1:0]     row_number_o;
  logic                 last_of_run_o;
  logic                 end_of_image_o;

  // typed expectation that travels with the current input beat
  logic   pin_en = 1'b0;
  pixel_t pin_px = '0;

  bpu_cfg_t    cfg;
  int unsigned byte_in_row = 0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  int unsigned gather_cnt = 0;
  logic [7:0]  gathered [4] = '{default: 8'h00};
  pixel_t      pixel_q [$];

  stim_row_t   dir_tbl [DIR_N];
  int          err_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          idling = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;

  bmp_pixel_unpacker_unit uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic pixel_t px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] bl,
                                input logic [7:0] a, input logic [OUT_COL_W-1:0] c,
                                input logic [ROW_W-1:0] rw, input logic l, input logic e);
    return '{r, g, bl, a, c, rw, l, e};
  endfunction

  function automatic stim_row_t brow(input logic [7:0] d);
    return '{STIM_BYTE, REG_PIXEL_MODE, {5'b0, d}, 1'b0, '0};
  endfunction

  function automatic stim_row_t prow(input logic [7:0] d, input pixel_t p);
    return '{STIM_BYTE, REG_PIXEL_MODE, {5'b0, d}, 1'b1, p};
  endfunction

  function automatic stim_row_t crow(input cfg_reg_e r, input logic [DIM_W-1:0] v);
    return '{STIM_CFG, r, v, 1'b0, '0};
  endfunction

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic pixel_t pixel_at(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] bl, input logic [7:0] a,
                                      input int unsigned w, input int unsigned h);
    return px(r, g, bl, a, OUT_COL_W'(col_cnt), ROW_W'(row_cnt), 1'b0,
              (row_cnt + 1 >= h) && (col_cnt + 1 == w));
  endfunction

  // Advances the unpacker state by one byte and queues the pixels it yields, or the pinned pixel in their place.
  function automatic void unpack_byte(input logic [7:0] d, input logic pinned, input pixel_t pin);
    int unsigned w, h, bpr, need, n, b;
    logic [7:0]  lvl;
    pixel_t      run [MAX_RUN];
    w = clamp_dim(cfg.width, MAX_WIDTH);
    h = clamp_dim(cfg.height, MAX_HEIGHT);
    n = 0;
    if (cfg.mode == MODE_MONO) begin
      bpr = ((w + 7) / 8 + 3) / 4 * 4;
      for (b = 0; b < 8; b++) begin
        if (col_cnt < w) begin
          lvl = d[7 - b] ? FULL_BYTE : EMPTY_BYTE;
          run[n] = pixel_at(lvl, lvl, lvl, FULL_BYTE, w, h);
          n++;
          col_cnt++;
        end
      end
    end else begin
      need = (cfg.mode == MODE_BGR) ? 3 : 4;
      bpr = (w * need + 3) / 4 * 4;
      if (col_cnt < w) begin
        gathered[gather_cnt % 4] = d;
        gather_cnt++;
        if (gather_cnt >= need) begin
          if (need == 3)
            run[n] = pixel_at(gathered[2], gathered[1], gathered[0], FULL_BYTE, w, h);
          else
            run[n] = pixel_at(gathered[cfg.red_pos], gathered[cfg.green_pos],
                              gathered[cfg.blue_pos], gathered[cfg.alpha_pos], w, h);
          n++;
          col_cnt++;
          gather_cnt = 0;
        end
      end
    end
    if (n > 0) run[n - 1].last_of_run = 1'b1;
    if (pinned) begin
      pixel_q.push_back(pin);
    end else begin
      for (b = 0; b < n; b++) pixel_q.push_back(run[b]);
    end
    if (byte_in_row + 1 >= bpr) begin
      byte_in_row = 0;
      col_cnt = 0;
      gather_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      byte_in_row++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [DIM_W-1:0] v);
    settle_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_PIXEL_MODE:   cfg.mode = pixel_mode_e'(v[1:0]);
      REG_IMAGE_WIDTH:  cfg.width = v;
      REG_IMAGE_HEIGHT: cfg.height = v;
      REG_RED_POS:      cfg.red_pos = v[1:0];
      REG_GREEN_POS:    cfg.green_pos = v[1:0];
      REG_BLUE_POS:     cfg.blue_pos = v[1:0];
      REG_ALPHA_POS:    cfg.alpha_pos = v[1:0];
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] d, input logic pinned, input pixel_t pin);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    pin_en      <= pinned;
    pin_px      <= pin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin : scoreboard
    pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) unpack_byte(data_byte_i, pin_en, pin_px);
      if (out_valid_o && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          $error("pixel beat with none expected: column %0d row %0d", column_o, row_number_o);
          err_cnt++;
        end else begin
          want = pixel_q.pop_front();
          check_field("red", want.red, red_o);
          check_field("green", want.green, green_o);
          check_field("blue", want.blue, blue_o);
          check_field("alpha", want.alpha, alpha_o);
          check_field("column", want.column, column_o);
          check_field("row_number", want.row_number, row_number_o);
          check_field("last_of_run", want.last_of_run, last_of_run_o);
          check_field("end_of_image", want.end_of_image, end_of_image_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : sink_pacing
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (idling ? $urandom_range(1, 24) : 1) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent, phase, nbytes, bpr, wv, hv, k;
    pixel_mode_e m;
    cfg = '{MODE_BGR, 13'd1, 13'd1, 2'd2, 2'd1, 2'd0, 2'd3};
    dir_tbl = '{
      // reset setup: 24-bit BGR, 1x1, one pad byte per row
      brow(8'hFF), brow(8'hFF),
      prow(8'hFF, px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 1, 1)), brow(8'hFF),
      brow(8'h12), brow(8'h34),
      prow(8'h56, px(8'h56, 8'h34, 8'h12, 8'hFF, 0, 0, 1, 1)), brow(8'hA5),
      // mono, zero width acts as one
      crow(REG_PIXEL_MODE, MODE_MONO), crow(REG_IMAGE_WIDTH, 0),
      prow(8'h7F, px(8'h00, 8'h00, 8'h00, 8'hFF, 0, 0, 1, 1)),
      brow(8'h00), brow(8'hFF), brow(8'h00),
      // ten-pixel mono row: second byte only partly used
      crow(REG_IMAGE_WIDTH, 10), crow(REG_IMAGE_HEIGHT, 2),
      brow(8'hA5), brow(8'hC0), brow(8'h00), brow(8'h00),
      // mode 3 as bitfields; zero height, row counter already past it
      crow(REG_PIXEL_MODE, MODE_BITFIELD_ALT), crow(REG_IMAGE_WIDTH, 1),
      crow(REG_IMAGE_HEIGHT, 0),
      brow(8'h11), brow(8'h22), brow(8'h33), brow(8'h44)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == STIM_CFG)
        write_reg(dir_tbl[i].reg_sel, dir_tbl[i].value);
      else
        push_byte(dir_tbl[i].value[7:0], dir_tbl[i].pinned, dir_tbl[i].pix);
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      idling = (sent + 40 < RAND_ITEMS);
      case (phase)
        0: begin m = MODE_BGR;      wv = 16;   hv = 2;    nbytes = 48; end
        1: begin m = MODE_BITFIELD; wv = 8191; hv = 8191; nbytes = 12; end
        2: begin m = MODE_MONO;     wv = 4096; hv = 4096; nbytes = 6;  end
        default: begin
          m  = pixel_mode_e'($urandom_range(0, 3));
          wv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
          hv = $urandom_range(0, 3);
          k  = (wv == 0) ? 1 : wv;
          case (m)
            MODE_MONO: bpr = ((k + 7) / 8 + 3) / 4 * 4;
            MODE_BGR:  bpr = (k * 3 + 3) / 4 * 4;
            default:   bpr = k * 4;
          endcase
          nbytes = bpr * $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, bpr - 1);
          if (nbytes > 64) nbytes = 64;
        end
      endcase
      write_reg(REG_PIXEL_MODE, {11'($urandom), m});
      write_reg(REG_IMAGE_WIDTH, 13'(wv));
      write_reg(REG_IMAGE_HEIGHT, 13'(hv));
      write_reg(REG_RED_POS, {11'($urandom), 2'($urandom)});
      write_reg(REG_GREEN_POS, {11'($urandom), 2'($urandom)});
      write_reg(REG_BLUE_POS, {11'($urandom), 2'($urandom)});
      write_reg(REG_ALPHA_POS, {11'($urandom), 2'($urandom)});
      // output held off while a full row is offered
      if (phase == 0) begin
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
      end
      repeat (nbytes) push_byte(8'($urandom), 1'b0, '0);
      sent += nbytes;
      phase++;
    end

    settle_pipeline();
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
